// ----- sv/lbe_pkg.sv -----
// shared types and constants of the lagrange basis evaluator
package lbe_pkg;

  localparam int NREG = 7;
  localparam int XW = 32;
  localparam int CNT_W = 3;
  localparam int OW = 48;
  localparam int QW = 49;
  localparam int FRAC = 32;
  localparam int LANES = 3;
  localparam int LO_W = 17;
  localparam int SH1 = 13;
  localparam int SH2 = 43;

  localparam logic [CNT_W-1:0] CFG_NODE_COUNT = 3'd0;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_RANGE = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

  typedef struct packed {
    logic oor;
    logic dup;
  } flag_t;

endpackage

// ----- sv/lbe_prod_cell.sv -----
// product cell: folds one node into the basis numerators and the denominator
module lbe_prod_cell #(
  parameter int BW = 194,
  parameter int J = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [2:0]           cnt,
  input  logic signed [31:0]   node,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   y_in,
  input  logic signed [31:0]   xm_in,
  input  logic [2:0]           m_in,
  input  lbe_pkg::flag_t       flag_in,
  input  logic signed [BW-1:0] n0_in,
  input  logic signed [BW-1:0] n1_in,
  input  logic signed [BW-1:0] n2_in,
  input  logic signed [BW-1:0] d_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   y_out,
  output logic signed [31:0]   xm_out,
  output logic [2:0]           m_out,
  output lbe_pkg::flag_t       flag_out,
  output logic signed [BW-1:0] n0_out,
  output logic signed [BW-1:0] n1_out,
  output logic signed [BW-1:0] n2_out,
  output logic signed [BW-1:0] d_out
);
  import lbe_pkg::*;

  localparam logic [2:0] JI = 3'(J);
  localparam int NOP = 4;
  localparam int NL = (BW + 31) / 32;
  localparam int EW = NL * 32;

  logic                           load;
  logic                           mid_load;
  logic                           mid_valid;
  logic                           act;
  logic signed [32:0]             f;
  logic signed [32:0]             g;
  logic [NOP-1:0][EW-1:0]         ext;
  logic [NOP-1:0][NL-1:0][65:0]   pp;
  flag_t                          flag_next;
  logic signed [31:0]             mid_y;
  logic signed [31:0]             mid_xm;
  logic [2:0]                     mid_m;
  flag_t                          mid_flag;
  logic                           mid_act;
  logic signed [BW-1:0]           mid_n0, mid_n1, mid_n2, mid_d;
  logic [NOP-1:0][NL-1:0][65:0]   mid_pp;
  logic [NOP-1:0][BW-1:0]         acc;
  logic signed [BW-1:0]           n0_next, n1_next, n2_next, d_next;

  assign load = !out_valid || out_ready;
  assign mid_load = !mid_valid || load;
  assign in_ready = mid_load;

  // first stage: 32-bit limb products of each operand
  always_comb begin
    act = (JI < cnt) && (m_in != JI);
    f = 33'(y_in) - 33'(node);
    g = 33'(xm_in) - 33'(node);
    flag_next = flag_in;
    if (act && (node == xm_in)) begin
      flag_next.dup = 1'b1;
    end
    ext[0] = EW'(n0_in);
    ext[1] = EW'(n1_in);
    ext[2] = EW'(n2_in);
    ext[3] = EW'(d_in);
    for (int o = 0; o < NOP; o++) begin
      for (int k = 0; k < NL; k++) begin
        pp[o][k] = 66'($signed({(k == NL - 1) && ext[o][32*k+31], ext[o][32*k +: 32]})
                       * ((o == NOP - 1) ? g : f));
      end
    end
  end

  // second stage: limb products summed into the new numerators and denominator
  always_comb begin
    for (int o = 0; o < NOP; o++) begin
      acc[o] = '0;
      for (int k = 0; k < NL; k++) begin
        acc[o] = acc[o] + (BW'($signed(mid_pp[o][k])) << (32 * k));
      end
    end
    if (mid_act) begin
      n0_next = $signed(acc[0]);
      n1_next = $signed(acc[1]) + mid_n0;
      n2_next = $signed(acc[2]) + (mid_n1 <<< 1);
      d_next = $signed(acc[3]);
    end else begin
      n0_next = mid_n0;
      n1_next = mid_n1;
      n2_next = mid_n2;
      d_next = mid_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (mid_load) begin
        mid_valid <= in_valid;
      end
      if (load) begin
        out_valid <= mid_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mid_load && in_valid) begin
      mid_y <= y_in;
      mid_xm <= xm_in;
      mid_m <= m_in;
      mid_flag <= flag_next;
      mid_act <= act;
      mid_n0 <= n0_in;
      mid_n1 <= n1_in;
      mid_n2 <= n2_in;
      mid_d <= d_in;
      mid_pp <= pp;
    end
  end

  always_ff @(posedge clk) begin
    if (load && mid_valid) begin
      y_out <= mid_y;
      xm_out <= mid_xm;
      m_out <= mid_m;
      flag_out <= mid_flag;
      n0_out <= n0_next;
      n1_out <= n1_next;
      n2_out <= n2_next;
      d_out <= d_next;
    end
  end

endmodule

// ----- sv/lbe_div_cell.sv -----
// divider cell: one quotient bit for each of the three lanes
module lbe_div_cell #(
  parameter int BW = 194,
  parameter int K = 48
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  lbe_pkg::flag_t                         flag_in,
  input  logic [lbe_pkg::LANES-1:0]              neg_in,
  input  logic [lbe_pkg::LANES-1:0]              sat_in,
  input  logic [BW-1:0]                          d_in,
  input  logic [lbe_pkg::LO_W-1:0]               nlo_in,
  input  logic [lbe_pkg::LANES-1:0][BW:0]        r_in,
  input  logic [lbe_pkg::LANES-1:0][lbe_pkg::QW-1:0] q_in,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output lbe_pkg::flag_t                         flag_out,
  output logic [lbe_pkg::LANES-1:0]              neg_out,
  output logic [lbe_pkg::LANES-1:0]              sat_out,
  output logic [BW-1:0]                          d_out,
  output logic [lbe_pkg::LO_W-1:0]               nlo_out,
  output logic [lbe_pkg::LANES-1:0][BW:0]        r_out,
  output logic [lbe_pkg::LANES-1:0][lbe_pkg::QW-1:0] q_out
);
  import lbe_pkg::*;

  localparam int RW = BW + 1;

  logic                              load;
  logic                              b0;
  logic [LANES-1:0]                  bin;
  logic [LANES-1:0][RW-1:0]          rs;
  logic [LANES-1:0]                  ge;
  logic [LANES-1:0][RW-1:0]          r_next;
  logic [LANES-1:0][QW-1:0]          q_next;

  generate
    if (K >= FRAC) begin : g_lo
      assign b0 = nlo_in[K-FRAC];
    end else begin : g_zero
      assign b0 = 1'b0;
    end
  endgenerate

  assign load = !out_valid || out_ready;
  assign in_ready = load;
  assign bin = {1'b0, 1'b0, b0};

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      rs[i] = {r_in[i][RW-2:0], bin[i]};
      ge[i] = rs[i] >= {1'b0, d_in};
      r_next[i] = ge[i] ? rs[i] - {1'b0, d_in} : rs[i];
      q_next[i] = q_in[i];
      q_next[i][K] = ge[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      flag_out <= flag_in;
      neg_out <= neg_in;
      sat_out <= sat_in;
      d_out <= d_in;
      nlo_out <= nlo_in;
      r_out <= r_next;
      q_out <= q_next;
    end
  end

endmodule

// ----- sv/lagrange_basis_eval_unit.sv -----
// top level: lagrange basis value and derivatives through product and divider cell rows
//
//  channel | signals                                   | transfer
//  in      | eval_point, basis_index                   | in_valid && in_ready
//  out     | basis_value, first/second_derivative, status | out_valid && out_ready
//  cfg     | cfg_index, cfg_data                       | cfg_we
//
// one item enters per cycle while in_ready is high; its path runs through the entry register,
// two stages per product cell (limb products, then their sum), a prep stage,
// 49 divider cells (one quotient bit each) and the output register.
// rst clears all valid bits and loads the reset node set.
// each stage holds its item while its successor is full and stalled, so a stalled output
// backs up one stage at a time and inputs keep flowing into empty stages.
module lagrange_basis_eval_unit #(
  parameter int MAX_NODES = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  eval_point,
  input  logic [2:0]          basis_index,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [47:0]  basis_value,
  output logic signed [47:0]  first_derivative,
  output logic signed [47:0]  second_derivative,
  output logic [1:0]          status
);
  import lbe_pkg::*;

  localparam int BW = 32 * (MAX_NODES - 1) + 2;
  localparam int RW = BW + 1;
  localparam int IW = BW + SH2;
  localparam int NDIV = QW;

  logic [2:0]         node_count;
  logic signed [31:0] node [NREG];
  logic [2:0]         cnt_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= 3'd2;
      for (int i = 0; i < NREG; i++) begin
        node[i] <= '0;
      end
      node[0] <= 32'shC000_0000;
      node[1] <= 32'sh4000_0000;
    end else if (cfg_we) begin
      if (cfg_index == CFG_NODE_COUNT) begin
        node_count <= cfg_data[2:0];
      end else begin
        node[3'(cfg_index - 3'd1)] <= cfg_data;
      end
    end
  end

  assign cnt_eff = (node_count > 3'(MAX_NODES)) ? 3'(MAX_NODES) : node_count;

  // product row
  logic                 pv   [MAX_NODES+1];
  logic                 prdy [MAX_NODES+1];
  logic signed [31:0]   py   [MAX_NODES+1];
  logic signed [31:0]   pxm  [MAX_NODES+1];
  logic [2:0]           pm   [MAX_NODES+1];
  flag_t                pf   [MAX_NODES+1];
  logic signed [BW-1:0] pn0  [MAX_NODES+1];
  logic signed [BW-1:0] pn1  [MAX_NODES+1];
  logic signed [BW-1:0] pn2  [MAX_NODES+1];
  logic signed [BW-1:0] pd   [MAX_NODES+1];

  logic               in_load;
  logic signed [31:0] xm_sel;

  assign in_load = !pv[0] || prdy[0];
  assign in_ready = in_load;
  assign xm_sel = (basis_index < 3'(NREG)) ? node[basis_index] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv[0] <= 1'b0;
    end else if (in_load) begin
      pv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && in_valid) begin
      py[0] <= eval_point;
      pxm[0] <= xm_sel;
      pm[0] <= basis_index;
      pf[0].oor <= basis_index >= cnt_eff;
      pf[0].dup <= 1'b0;
      pn0[0] <= BW'(1);
      pn1[0] <= '0;
      pn2[0] <= '0;
      pd[0] <= BW'(1);
    end
  end

  generate
    for (genvar j = 0; j < MAX_NODES; j++) begin : g_prod
      lbe_prod_cell #(.BW(BW), .J(j)) u_cell (
        .clk       (clk),
        .rst       (rst),
        .cnt       (cnt_eff),
        .node      (node[j]),
        .in_valid  (pv[j]),
        .in_ready  (prdy[j]),
        .y_in      (py[j]),
        .xm_in     (pxm[j]),
        .m_in      (pm[j]),
        .flag_in   (pf[j]),
        .n0_in     (pn0[j]),
        .n1_in     (pn1[j]),
        .n2_in     (pn2[j]),
        .d_in      (pd[j]),
        .out_valid (pv[j+1]),
        .out_ready (prdy[j+1]),
        .y_out     (py[j+1]),
        .xm_out    (pxm[j+1]),
        .m_out     (pm[j+1]),
        .flag_out  (pf[j+1]),
        .n0_out    (pn0[j+1]),
        .n1_out    (pn1[j+1]),
        .n2_out    (pn2[j+1]),
        .d_out     (pd[j+1])
      );
    end
  endgenerate

  // divider row
  logic                         dv   [NDIV+1];
  logic                         drdy [NDIV+1];
  flag_t                        df   [NDIV+1];
  logic [LANES-1:0]             dneg [NDIV+1];
  logic [LANES-1:0]             dsat [NDIV+1];
  logic [BW-1:0]                dd   [NDIV+1];
  logic [LO_W-1:0]              dlo  [NDIV+1];
  logic [LANES-1:0][RW-1:0]     dr   [NDIV+1];
  logic [LANES-1:0][QW-1:0]     dq   [NDIV+1];

  // prep: magnitudes, signs and the leading remainder check
  logic                     prep_load;
  logic [LANES-1:0][BW-1:0] na;
  logic [BW-1:0]            da;
  logic [LANES-1:0][IW-1:0] init;
  logic [LANES-1:0]         neg_p;
  logic [LANES-1:0]         sat_p;
  logic [LANES-1:0][RW-1:0] r_p;
  logic signed [BW-1:0]     nsel [LANES];

  assign prep_load = !dv[0] || drdy[0];
  assign prdy[MAX_NODES] = prep_load;

  always_comb begin
    nsel[0] = pn0[MAX_NODES];
    nsel[1] = pn1[MAX_NODES];
    nsel[2] = pn2[MAX_NODES];
    da = pd[MAX_NODES][BW-1] ? BW'(-pd[MAX_NODES]) : BW'(pd[MAX_NODES]);
    for (int i = 0; i < LANES; i++) begin
      na[i] = nsel[i][BW-1] ? BW'(-nsel[i]) : BW'(nsel[i]);
      neg_p[i] = nsel[i][BW-1] ^ pd[MAX_NODES][BW-1];
    end
    init[0] = IW'(na[0] >> LO_W);
    init[1] = IW'(na[1]) << SH1;
    init[2] = IW'(na[2]) << SH2;
    for (int i = 0; i < LANES; i++) begin
      sat_p[i] = init[i] >= IW'(da);
      r_p[i] = sat_p[i] ? '0 : RW'(init[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (prep_load) begin
      dv[0] <= pv[MAX_NODES];
    end
  end

  always_ff @(posedge clk) begin
    if (prep_load && pv[MAX_NODES]) begin
      df[0] <= pf[MAX_NODES];
      dneg[0] <= neg_p;
      dsat[0] <= sat_p;
      dd[0] <= da;
      dlo[0] <= na[0][LO_W-1:0];
      dr[0] <= r_p;
      dq[0] <= '0;
    end
  end

  generate
    for (genvar c = 0; c < NDIV; c++) begin : g_div
      lbe_div_cell #(.BW(BW), .K(QW - 1 - c)) u_cell (
        .clk       (clk),
        .rst       (rst),
        .in_valid  (dv[c]),
        .in_ready  (drdy[c]),
        .flag_in   (df[c]),
        .neg_in    (dneg[c]),
        .sat_in    (dsat[c]),
        .d_in      (dd[c]),
        .nlo_in    (dlo[c]),
        .r_in      (dr[c]),
        .q_in      (dq[c]),
        .out_valid (dv[c+1]),
        .out_ready (drdy[c+1]),
        .flag_out  (df[c+1]),
        .neg_out   (dneg[c+1]),
        .sat_out   (dsat[c+1]),
        .d_out     (dd[c+1]),
        .nlo_out   (dlo[c+1]),
        .r_out     (dr[c+1]),
        .q_out     (dq[c+1])
      );
    end
  endgenerate

  // rounding, saturation and status into the output register
  localparam logic [QW:0] POS_LIM = (QW+1)'((64'd1 << (OW - 1)) - 64'd1);
  localparam logic [QW:0] NEG_LIM = (QW+1)'(64'd1 << (OW - 1));
  localparam logic [OW-1:0] POS_VAL = {1'b0, {(OW-1){1'b1}}};
  localparam logic [OW-1:0] NEG_VAL = {1'b1, {(OW-1){1'b0}}};

  logic                     out_load;
  logic [LANES-1:0][QW:0]   qr;
  logic [LANES-1:0]         sat_f;
  logic [LANES-1:0][OW-1:0] val;
  status_t                  st_next;
  logic [OW-1:0]            v0, v1, v2;
  status_t                  st_reg;

  assign out_load = !out_valid || out_ready;
  assign drdy[NDIV] = out_load;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      qr[i] = (QW+1)'(dq[NDIV][i])
            + (QW+1)'({dr[NDIV][i], 1'b0} >= (RW+1)'(dd[NDIV]));
      sat_f[i] = dsat[NDIV][i]
               || (!dneg[NDIV][i] && (qr[i] > POS_LIM))
               || (dneg[NDIV][i] && (qr[i] > NEG_LIM));
      if (sat_f[i]) begin
        val[i] = dneg[NDIV][i] ? NEG_VAL : POS_VAL;
      end else if (dneg[NDIV][i]) begin
        val[i] = OW'(-qr[i]);
      end else begin
        val[i] = OW'(qr[i]);
      end
    end
    if (df[NDIV].oor) begin
      st_next = ST_RANGE;
    end else if (df[NDIV].dup) begin
      st_next = ST_DUP;
    end else if (|sat_f) begin
      st_next = ST_SAT;
    end else begin
      st_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= dv[NDIV];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && dv[NDIV]) begin
      st_reg <= st_next;
      if (df[NDIV].oor || df[NDIV].dup) begin
        v0 <= '0;
        v1 <= '0;
        v2 <= '0;
      end else begin
        v0 <= val[0];
        v1 <= val[1];
        v2 <= val[2];
      end
    end
  end

  assign basis_value = v0;
  assign first_derivative = v1;
  assign second_derivative = v2;
  assign status = st_reg;

endmodule

// ----- test/lagrange_basis_eval_unit_chk.sv -----
// checker: predicts basis value and derivatives per transfer and compares results
module lagrange_basis_eval_unit_chk (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] eval_point,
  input  logic [2:0]         basis_index,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [47:0] basis_value,
  input  logic signed [47:0] first_derivative,
  input  logic signed [47:0] second_derivative,
  input  logic [1:0]         status,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import lbe_pkg::*;

  localparam int MAX_NODES = 7;
  localparam int BW = 400;

  typedef struct packed {
    logic signed [47:0] value;
    logic signed [47:0] d1;
    logic signed [47:0] d2;
    status_t            st;
  } basis_result_t;

  logic [2:0]         node_cnt;
  logic signed [31:0] nodes [NREG];
  basis_result_t      expected_q [$];

  // round(num * 2^shift / den) to nearest, ties away from zero; msb flags saturation
  function automatic logic [48:0] scaled_quotient(logic signed [BW-1:0] num,
                                                  logic signed [BW-1:0] den, int shift);
    logic [BW-1:0] an, ad, q, r;
    bit neg;
    neg = num[BW-1] ^ den[BW-1];
    an = num[BW-1] ? -num : num;
    ad = den[BW-1] ? -den : den;
    an = an << shift;
    q = an / ad;
    r = an - q * ad;
    if ((r << 1) >= ad) q = q + 1;
    if (!neg) begin
      if (q > BW'(48'h7FFF_FFFF_FFFF)) return {1'b1, 48'h7FFF_FFFF_FFFF};
      return {1'b0, q[47:0]};
    end
    if (q > BW'(48'h8000_0000_0000)) return {1'b1, 48'h8000_0000_0000};
    return {1'b0, 48'd0 - q[47:0]};
  endfunction

  function automatic basis_result_t basis_predict(logic signed [31:0] y, logic [2:0] m);
    basis_result_t r;
    logic signed [BW-1:0] xs [NREG];
    logic signed [BW-1:0] ys, den, n0, n1, n2, t;
    logic [48:0] q0, q1, q2;
    int cnt;
    bit dup;
    r = '0;
    r.st = ST_OK;
    cnt = (node_cnt > MAX_NODES) ? MAX_NODES : node_cnt;
    if (m >= cnt) begin
      r.st = ST_RANGE;
      return r;
    end
    ys = y;
    for (int i = 0; i < cnt; i++) xs[i] = nodes[i];
    dup = 0;
    for (int j = 0; j < cnt; j++)
      if (j != m && xs[j] == xs[m]) dup = 1;
    if (dup) begin
      r.st = ST_DUP;
      return r;
    end
    den = 1;
    n0 = 1;
    n1 = 0;
    n2 = 0;
    for (int j = 0; j < cnt; j++) begin
      if (j == m) continue;
      den = den * (xs[m] - xs[j]);
      n0 = n0 * (ys - xs[j]);
    end
    for (int i = 0; i < cnt; i++) begin
      if (i == m) continue;
      t = 1;
      for (int j = 0; j < cnt; j++)
        if (j != m && j != i) t = t * (ys - xs[j]);
      n1 = n1 + t;
      for (int j = 0; j < cnt; j++) begin
        if (j == m || j == i) continue;
        t = 1;
        for (int k = 0; k < cnt; k++)
          if (k != m && k != i && k != j) t = t * (ys - xs[k]);
        n2 = n2 + t;
      end
    end
    q0 = scaled_quotient(n0, den, 32);
    q1 = scaled_quotient(n1, den, 62);
    q2 = scaled_quotient(n2, den, 92);
    r.value = q0[47:0];
    r.d1 = q1[47:0];
    r.d2 = q2[47:0];
    if (q0[48] || q1[48] || q2[48]) r.st = ST_SAT;
    return r;
  endfunction

  always @(posedge clk) begin
    basis_result_t exp_r;
    if (rst) begin
      node_cnt <= 3'd2;
      for (int i = 0; i < NREG; i++) nodes[i] <= '0;
      nodes[0] <= 32'hC000_0000;
      nodes[1] <= 32'h4000_0000;
      expected_q.delete();
      errors <= 0;
      pending <= 0;
    end else begin
      if (in_valid && in_ready) expected_q.push_back(basis_predict(eval_point, basis_index));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          if (errors < 10) $display("unexpected result transfer at %0t", $realtime);
          errors <= errors + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (basis_value !== exp_r.value || first_derivative !== exp_r.d1 ||
              second_derivative !== exp_r.d2 || status !== exp_r.st) begin
            if (errors < 10)
              $display("mismatch at %0t: exp %h %h %h %0d got %h %h %h %0d", $realtime,
                       exp_r.value, exp_r.d1, exp_r.d2, exp_r.st, basis_value,
                       first_derivative, second_derivative, status);
            errors <= errors + 1;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_NODE_COUNT) node_cnt <= cfg_data[2:0];
        else nodes[3'(cfg_index - 3'd1)] <= cfg_data;
      end
      pending <= expected_q.size();
    end
  end

endmodule

// ----- test/lagrange_basis_eval_unit_tb.sv -----
// testbench top: stimulus, configuration phases and verdict for the basis evaluator
module lagrange_basis_eval_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lbe_pkg::*;

  localparam int MAX_NODES = 7;
  localparam logic [2:0] CFG_NODE_BASE = 3'd1;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] eval_point;
  logic [2:0]         basis_index;
  logic               out_valid;
  logic               out_ready;
  logic signed [47:0] basis_value;
  logic signed [47:0] first_derivative;
  logic signed [47:0] second_derivative;
  logic [1:0]         status;
  int                 errors;
  int                 pending;
  int                 burst_left;
  logic [31:0]        node_set [NREG];
  int                 active_cnt;

  lagrange_basis_eval_unit #(.MAX_NODES(MAX_NODES)) uut (.*);

  lagrange_basis_eval_unit_chk chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("lagrange_basis_eval_unit_tb: errors");
    $finish;
  end

  // receiver stall pattern
  initial begin
    int mode, cyc;
    out_ready = 1'b0;
    cyc = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_ready = 1'b1;
        1: out_ready = ($urandom_range(0, 3) != 0);
        2: out_ready = ((cyc % 16) < 4);
        default: out_ready = $urandom_range(0, 1);
      endcase
      cyc++;
    end
  end

  task automatic send_item(logic [31:0] y, logic [2:0] m);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_valid = 1'b1;
    eval_point = y;
    basis_index = m;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (MAX_NODES + 60) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_nodes(int cnt);
    active_cnt = cnt;
    write_reg(CFG_NODE_COUNT, 32'(cnt));
    for (int i = 0; i < NREG; i++) write_reg(CFG_NODE_BASE + 3'(i), node_set[i]);
  endtask

  function automatic logic [31:0] pick_point();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return node_set[$urandom_range(0, NREG - 1)];
      2: return node_set[$urandom_range(0, NREG - 1)] + $urandom_range(0, 64) - 32;
      3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return 32'($signed($urandom_range(0, 32'h8000_0000))) - 32'h4000_0000;
    endcase
  endfunction

  initial begin
    logic [31:0] dirs [8];
    int style, cnt;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    eval_point = '0;
    basis_index = '0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset nodes: extremes of the point, both bases, out of range indexes
    dirs = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hC000_0000, 32'h4000_0000,
             32'h2000_0000, 32'hFFFF_FFFF, 32'h0000_0001};
    for (int i = 0; i < 8; i++) send_item(dirs[i], 3'(i % 2));
    send_item(32'h1234_5678, 3'd2);
    send_item(32'h8000_0000, 3'd7);
    wait_idle();

    // single node, zero count and full count with extreme nodes
    node_set = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h2000_0000, 32'hE000_0000,
                 32'h1000_0000, 32'hF000_0000};
    load_nodes(1);
    send_item(32'h7FFF_FFFF, 3'd0);
    send_item(32'h8000_0000, 3'd1);
    wait_idle();
    load_nodes(0);
    send_item(32'h0, 3'd0);
    wait_idle();
    load_nodes(7);
    for (int i = 0; i < 8; i++) send_item(i[0] ? 32'h7FFF_FFFF : 32'h8000_0000, 3'(i));
    wait_idle();

    // duplicates and nodes one step apart
    node_set = '{32'h0, 32'h0000_0001, 32'h0, 32'h4000_0000, 32'h4000_0000,
                 32'hC000_0000, 32'h2000_0000};
    load_nodes(6);
    for (int i = 0; i < 6; i++) send_item(32'h7FFF_FFFF, 3'(i));
    wait_idle();

    for (int phase = 0; phase < 26; phase++) begin
      style = $urandom_range(0, 3);
      cnt = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 7);
      for (int i = 0; i < NREG; i++) begin
        case (style)
          0: node_set[i] = $urandom();
          1: node_set[i] = 32'((i - 3) * 32'sh1000_0000) + $urandom_range(0, 32'hFF_FFFF);
          2: node_set[i] = 32'h1000_0000 + $urandom_range(0, 255);
          default: node_set[i] = 32'(i * 32'sh2000_0000) + 32'h8000_0000;
        endcase
      end
      if ($urandom_range(0, 5) == 0)
        node_set[$urandom_range(0, NREG - 1)] = node_set[$urandom_range(0, NREG - 1)];
      load_nodes(cnt);
      for (int k = 0; k < 60; k++)
        send_item(pick_point(), ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                               : 3'($urandom_range(0, (active_cnt > 0) ? active_cnt - 1 : 0)));
      wait_idle();
    end

    if (errors == 0) begin
      $display("lagrange_basis_eval_unit_tb: clean");
    end else begin
      $display("lagrange_basis_eval_unit_tb: errors");
    end
    $finish;
  end

endmodule
